### src/dq_pkg.sv
// dq_pkg: shared types and constants for the double-ended queue.
// Depends on nothing; used by the interfaces, cells, chain, top level and checker.

package dq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_REAR  = 3'd1,
    REQ_REM_FRONT = 3'd2,
    REQ_REM_REAR  = 3'd3,
    REQ_DISPLAY   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what every cell does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,    // take left neighbour (cell 0 takes the new word)
    CELL_POP,     // take right neighbour
    CELL_LOAD,    // selected cell takes the new word
    CELL_ROTATE   // take right neighbour; selected cell takes cell 0
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] sel;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_e;

endpackage

### src/dq_if.sv
// dq_req_if / dq_rsp_if: valid/ready channels carrying requests and results.
// Depends on dq_pkg for field widths.

interface dq_req_if;
  logic                              valid;
  logic                              ready;
  logic [dq_pkg::REQ_W-1:0]          req_type;
  logic signed [dq_pkg::WORD_W-1:0]  item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface dq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::WORD_W-1:0]  out_value;
  logic [dq_pkg::STAT_W-1:0]         status;
  logic                              last;

  modport source (output valid, output out_value, output status, output last, input ready);
  modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

### src/dq_cell.sv
// dq_cell: one storage cell of the deque chain, fed by its neighbours.
// Depends on dq_pkg.

module dq_cell (
  input  logic                             clk_i,
  input  dq_pkg::cell_ctrl_t               ctrl_i,
  input  logic [dq_pkg::IDX_W-1:0]         idx_i,
  input  logic signed [dq_pkg::WORD_W-1:0] left_i,
  input  logic signed [dq_pkg::WORD_W-1:0] right_i,
  input  logic signed [dq_pkg::WORD_W-1:0] head_i,
  input  logic signed [dq_pkg::WORD_W-1:0] item_i,
  output logic signed [dq_pkg::WORD_W-1:0] word_o
);

  logic signed [dq_pkg::WORD_W-1:0] word_q, word_d;
  logic                             hit;

  assign hit = (idx_i == ctrl_i.sel);

  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.op)
      dq_pkg::CELL_HOLD:   word_d = word_q;
      dq_pkg::CELL_PUSH:   word_d = left_i;
      dq_pkg::CELL_POP:    word_d = right_i;
      dq_pkg::CELL_LOAD:   word_d = hit ? item_i : word_q;
      dq_pkg::CELL_ROTATE: word_d = hit ? head_i : right_i;
      default:             word_d = word_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

### src/dq_chain.sv
// dq_chain: row of dq_cell storage cells, front word in cell 0.
// Depends on dq_pkg and dq_cell.

module dq_chain (
  input  logic                             clk_i,
  input  dq_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [dq_pkg::WORD_W-1:0] item_i,
  output logic signed [dq_pkg::WORD_W-1:0] head_o,
  output logic signed [dq_pkg::WORD_W-1:0] sel_word_o
);

  logic signed [dq_pkg::WORD_W-1:0] words [dq_pkg::DEPTH];

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    logic signed [dq_pkg::WORD_W-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = item_i;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    dq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (dq_pkg::IDX_W'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (words[0]),
      .item_i  (item_i),
      .word_o  (words[i])
    );
  end

  assign head_o     = words[0];
  // rear word for remove-from-rear
  assign sel_word_o = words[ctrl_i.sel];

endmodule

### src/double_ended_queue.sv
// double_ended_queue: deque of signed 32-bit words held in a chain of cells.
// Depends on dq_pkg, dq_req_if / dq_rsp_if and dq_chain.
//
//  channel | dir | modport | payload
//  --------+-----+---------+------------------------------
//  req_i   | in  | sink    | req_type, item_value
//  rsp_o   | out | source  | out_value, status, last
//
// An add or remove transfer loads the result register and, if the deque is not
// full or empty, updates the chain in the same cycle; remove-from-rear holds it.
// A display of N > 0 stored words first enters the show state, then rotates the
// chain once per result transfer; after N rotations the chain is back in its
// original order.
// Requests are taken only while idle and the result register is free or
// draining; a stalled result holds the chain and the display counter.
// Reset clears the fill count, the state and the result valid; cell contents
// stay undefined until written and are never read before that.

module double_ended_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_req_if.sink    req_i,
  dq_rsp_if.source  rsp_o
);

  dq_pkg::state_e      state_q, state_d;
  logic [dq_pkg::CNT_W-1:0] count_q, count_d;
  logic [dq_pkg::CNT_W-1:0] remain_q, remain_d;
  logic                out_valid_q, out_valid_d;
  logic signed [dq_pkg::WORD_W-1:0] out_value_q, out_value_d;
  dq_pkg::status_e     out_status_q, out_status_d;
  logic                out_last_q, out_last_d;

  dq_pkg::cell_ctrl_t  ctrl;
  logic signed [dq_pkg::WORD_W-1:0] head_word, sel_word;
  logic                slot_free, in_fire, is_full, is_empty;
  logic [dq_pkg::CNT_W-1:0] count_m1;
  dq_pkg::req_e        req;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == dq_pkg::S_IDLE) && slot_free;
  assign in_fire   = req_i.valid && req_i.ready;
  assign req       = dq_pkg::req_e'(req_i.req_type);
  assign is_full   = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty  = (count_q == '0);
  assign count_m1  = count_q - dq_pkg::CNT_W'(1);

  dq_chain u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .item_i     (req_i.item_value),
    .head_o     (head_word),
    .sel_word_o (sel_word)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dq_pkg::S_IDLE: begin
        if (in_fire && req == dq_pkg::REQ_DISPLAY && !is_empty) begin
          state_d = dq_pkg::S_SHOW;
        end
      end
      dq_pkg::S_SHOW: begin
        if (slot_free && remain_q == dq_pkg::CNT_W'(1)) begin
          state_d = dq_pkg::S_IDLE;
        end
      end
      default: state_d = dq_pkg::S_IDLE;
    endcase
  end

  // chain control, count and result register
  always_comb begin
    ctrl.op      = dq_pkg::CELL_HOLD;
    ctrl.sel     = count_m1[dq_pkg::IDX_W-1:0];
    count_d      = count_q;
    remain_d     = remain_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      dq_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (req)
            dq_pkg::REQ_ADD_FRONT, dq_pkg::REQ_ADD_REAR: begin
              out_valid_d = 1'b1;
              out_value_d = req_i.item_value;
              out_last_d  = 1'b1;
              if (is_full) begin
                out_status_d = dq_pkg::ST_FULL;
              end else begin
                out_status_d = dq_pkg::ST_OK;
                count_d      = count_q + dq_pkg::CNT_W'(1);
                if (req == dq_pkg::REQ_ADD_FRONT) begin
                  ctrl.op = dq_pkg::CELL_PUSH;
                end else begin
                  ctrl.op  = dq_pkg::CELL_LOAD;
                  ctrl.sel = count_q[dq_pkg::IDX_W-1:0];
                end
              end
            end
            dq_pkg::REQ_REM_FRONT, dq_pkg::REQ_REM_REAR: begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b1;
              if (is_empty) begin
                out_value_d  = '0;
                out_status_d = dq_pkg::ST_EMPTY;
              end else begin
                out_status_d = dq_pkg::ST_OK;
                count_d      = count_m1;
                if (req == dq_pkg::REQ_REM_FRONT) begin
                  ctrl.op     = dq_pkg::CELL_POP;
                  out_value_d = head_word;
                end else begin
                  out_value_d = sel_word;  // rear cell, chain holds
                end
              end
            end
            dq_pkg::REQ_DISPLAY: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_status_d = dq_pkg::ST_EMPTY;
                out_last_d   = 1'b1;
              end else begin
                remain_d = count_q;
              end
            end
            default: ;  // unused codes: transfer taken, nothing happens
          endcase
        end
      end
      dq_pkg::S_SHOW: begin
        if (slot_free) begin
          // front word out, front cell goes round to the rear
          ctrl.op      = dq_pkg::CELL_ROTATE;
          out_valid_d  = 1'b1;
          out_value_d  = head_word;
          out_status_d = dq_pkg::ST_OK;
          out_last_d   = (remain_q == dq_pkg::CNT_W'(1));
          remain_d     = remain_q - dq_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_value = out_value_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.last      = out_last_q;

endmodule

### src/dq_checker.sv
// dq_checker: port-level assertions for double_ended_queue, plus its bind.
// Depends on dq_pkg; attached to the top level by the bind below.

module dq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic signed [dq_pkg::WORD_W-1:0] rsp_value_i,
  input logic [dq_pkg::STAT_W-1:0]        rsp_status_i,
  input logic                             rsp_last_i
);

  // stalled result transfer keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i)
      && $stable(rsp_status_i) && $stable(rsp_last_i))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == dq_pkg::ST_EMPTY |-> rsp_value_i == '0 && rsp_last_i)
    else $error("empty result not zero or not last");

  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == dq_pkg::ST_FULL |-> rsp_last_i)
    else $error("full result not last");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i == dq_pkg::ST_OK || rsp_status_i == dq_pkg::ST_EMPTY
      || rsp_status_i == dq_pkg::ST_FULL)
    else $error("undefined status code");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_value_i  (rsp_o.out_value),
  .rsp_status_i (rsp_o.status),
  .rsp_last_i   (rsp_o.last)
);
